// ----- hw/rtl/swrm_pkg.sv -----
package swrm_pkg;

  // Ring geometry.
  localparam int HistoryDepth = 64;
  localparam int IdxW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int CntW = $clog2(HistoryDepth + 1);
  localparam int SumW = IdxW + 1;

  // Field widths.
  localparam int TimeW    = 48;
  localparam int EvW      = 16;
  localparam int CostW    = 32;
  localparam int WindowW  = 32;
  localparam int MinW     = 7;
  localparam int SumEvW   = 23;
  localparam int SumCostW = 39;
  localparam int OutEvW   = 22;
  localparam int OutCostW = 38;
  localparam int SpanW    = 32;
  localparam int CmpW     = (CntW > MinW) ? CntW : MinW;

  // Stream and configuration port widths.
  localparam int InDataW  = TimeW + EvW + CostW;
  localparam int OutDataW = 96;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;

  // Register reset values.
  localparam int MinHistory        = 3;
  localparam int MaxSecondsPerItem = 5;
  localparam int MicroPerSecond    = 1000 * 1000;
  localparam logic [WindowW-1:0] WindowReset =
      WindowW'(MinHistory * MaxSecondsPerItem * MicroPerSecond);
  localparam logic [MinW-1:0] MinReset = MinW'(MinHistory);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW      = 1'b0,
    CFG_MIN_ENTRIES = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [TimeW-1:0] stamp;
    logic [CostW-1:0] cost;
    logic [EvW-1:0]   events;
  } ring_entry_t;

  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   addr;
    ring_entry_t       data;
  } ring_wr_t;

endpackage

// ----- hw/rtl/swrm_ring.sv -----
module swrm_ring (
  input  logic                        clk_i,
  input  swrm_pkg::ring_wr_t          wr_i,
  input  logic [swrm_pkg::IdxW-1:0]   rd_addr_i,
  output swrm_pkg::ring_entry_t       rd_data_o
);

  swrm_pkg::ring_entry_t mem_q [swrm_pkg::HistoryDepth];
  swrm_pkg::ring_entry_t rd_q;

  // A write to the address being read is forwarded, so the read port always
  // shows the current contents of the addressed entry.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_q <= wr_i.data;
    end else begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- hw/rtl/sliding_time_window_rate_meter.sv -----
// Channel  | Direction | Handshake                    | Contents
// s_axis   | in        | s_axis_tvalid, s_axis_tready | tuser: command; tdata: sample
// m_axis   | out       | m_axis_tvalid, m_axis_tready | tdata: cached rate and flags
// cfg      | in        | cfg_we_i, no wait            | window_us, min_entries
//
// A sample request passes through the start, limit, evict, overflow, append, cache and output
// states; in the evict state the single pop unit removes one expiring entry per cycle. A clear
// request goes straight to the output state. Reset is asynchronous and active low, and the ring
// contents need no clearing because only held entries are ever read.
// A finished result waits in the output register while the next request is accepted; the
// sequencer stalls only if a second result is ready before the first has been taken.
module sliding_time_window_rate_meter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Sample requests.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Bits from 0 up: now_us[47:0], events[63:48], cost_us[95:64].
  input  logic [swrm_pkg::InDataW-1:0]      s_axis_tdata,
  // Bit 0: command.
  input  logic                              s_axis_tuser,
  // Results.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Bits from 0 up: updated[0], idle[1], event_total[23:2], cost_total[61:24],
  // span_us[93:62], overflowed[94], zero pad[95].
  output logic [swrm_pkg::OutDataW-1:0]     m_axis_tdata,
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [swrm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [swrm_pkg::CfgDataW-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LIMIT,
    ST_EVICT,
    ST_OVF,
    ST_APPEND,
    ST_CACHE,
    ST_OUT
  } state_e;

  localparam int IdxW = swrm_pkg::IdxW;
  localparam int CntW = swrm_pkg::CntW;
  localparam int SumW = swrm_pkg::SumW;

  state_e state_q;

  // Configuration.
  logic [swrm_pkg::WindowW-1:0]  window_q;
  logic [swrm_pkg::MinW-1:0]     min_q;

  // Request being worked on.
  logic [swrm_pkg::TimeW-1:0]    now_q;
  logic [swrm_pkg::EvW-1:0]      ev_q;
  logic [swrm_pkg::CostW-1:0]    cost_q;
  logic [swrm_pkg::TimeW-1:0]    start_q;
  logic [swrm_pkg::TimeW-1:0]    limit_q;
  logic                          lim_ok_q;
  logic                          evicted_q;
  logic                          ovf_q;
  logic                          upd_q;

  // Ring bookkeeping and running sums.
  logic [IdxW-1:0]               head_q;
  logic [IdxW-1:0]               head_d;
  logic [CntW-1:0]               count_q;
  logic [swrm_pkg::SumEvW-1:0]   sum_ev_q;
  logic [swrm_pkg::SumCostW-1:0] sum_cost_q;

  // Rate cache.
  logic                          cache_idle_q;
  logic [swrm_pkg::SumEvW-1:0]   cache_ev_q;
  logic [swrm_pkg::SumCostW-1:0] cache_cost_q;
  logic [swrm_pkg::SpanW-1:0]    cache_span_q;

  // Output register.
  logic                          m_valid_q;
  logic [swrm_pkg::OutDataW-1:0] m_data_q;

  swrm_pkg::ring_wr_t            ring_wr;
  swrm_pkg::ring_entry_t         head_entry;

  logic                          in_fire;
  logic                          clear_req;
  logic                          evict_hit;
  logic                          pop;
  logic [IdxW-1:0]               head_inc;
  logic [SumW-1:0]               tail_sum;
  logic [IdxW-1:0]               tail;
  logic                          enough;
  logic                          out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign clear_req     = in_fire && (swrm_pkg::cmd_e'(s_axis_tuser) == swrm_pkg::CMD_CLEAR);
  assign out_free      = !m_valid_q || m_axis_tready;

  // An entry expires when its stamp is strictly below start minus the window.
  assign evict_hit = lim_ok_q && (count_q != '0) && (head_entry.stamp < limit_q);
  assign pop = ((state_q == ST_EVICT) && evict_hit) ||
               ((state_q == ST_OVF) && (count_q == CntW'(swrm_pkg::HistoryDepth)));

  assign head_inc = (head_q == IdxW'(swrm_pkg::HistoryDepth - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d = head_q;
    if (clear_req) begin
      head_d = '0;
    end else if (pop) begin
      head_d = head_inc;
    end
  end

  // The append slot sits count entries past the head, modulo the depth.
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail = (tail_sum >= SumW'(swrm_pkg::HistoryDepth)) ?
                IdxW'(tail_sum - SumW'(swrm_pkg::HistoryDepth)) : IdxW'(tail_sum);

  assign enough = (swrm_pkg::CmpW'(count_q) >= swrm_pkg::CmpW'(min_q));

  always_comb begin
    ring_wr.en          = (state_q == ST_APPEND);
    ring_wr.addr        = tail;
    ring_wr.data.stamp  = start_q;
    ring_wr.data.cost   = cost_q;
    ring_wr.data.events = ev_q;
  end

  // The read address follows the next head, so the registered read data
  // always holds the current oldest entry.
  swrm_ring u_ring (
    .clk_i     (clk_i),
    .wr_i      (ring_wr),
    .rd_addr_i (head_d),
    .rd_data_o (head_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_q     <= swrm_pkg::WindowReset;
      min_q        <= swrm_pkg::MinReset;
      now_q        <= '0;
      ev_q         <= '0;
      cost_q       <= '0;
      start_q      <= '0;
      limit_q      <= '0;
      lim_ok_q     <= 1'b0;
      evicted_q    <= 1'b0;
      ovf_q        <= 1'b0;
      upd_q        <= 1'b0;
      head_q       <= '0;
      count_q      <= '0;
      sum_ev_q     <= '0;
      sum_cost_q   <= '0;
      cache_idle_q <= 1'b1;
      cache_ev_q   <= '0;
      cache_cost_q <= '0;
      cache_span_q <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      head_q <= head_d;

      if (cfg_we_i) begin
        unique case (swrm_pkg::cfg_reg_e'(cfg_idx_i))
          swrm_pkg::CFG_WINDOW:      window_q <= cfg_data_i[swrm_pkg::WindowW-1:0];
          swrm_pkg::CFG_MIN_ENTRIES: min_q    <= cfg_data_i[swrm_pkg::MinW-1:0];
          default: ;
        endcase
      end

      // In the output state the new result takes the register instead.
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end

      // Shared pop unit: removes the head entry from the running sums.
      if (pop) begin
        sum_ev_q   <= sum_ev_q - swrm_pkg::SumEvW'(head_entry.events);
        sum_cost_q <= sum_cost_q - swrm_pkg::SumCostW'(head_entry.cost);
        count_q    <= count_q - 1'b1;
        evicted_q  <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          upd_q <= 1'b0;
          ovf_q <= 1'b0;
          if (clear_req) begin
            count_q      <= '0;
            sum_ev_q     <= '0;
            sum_cost_q   <= '0;
            cache_idle_q <= 1'b1;
            cache_ev_q   <= '0;
            cache_cost_q <= '0;
            cache_span_q <= '0;
            state_q      <= ST_OUT;
          end else if (in_fire) begin
            now_q   <= s_axis_tdata[swrm_pkg::TimeW-1:0];
            ev_q    <= s_axis_tdata[swrm_pkg::TimeW +: swrm_pkg::EvW];
            cost_q  <= s_axis_tdata[swrm_pkg::TimeW + swrm_pkg::EvW +: swrm_pkg::CostW];
            state_q <= ST_START;
          end
        end
        ST_START: begin
          // Start time saturates at zero when the cost exceeds the clock.
          start_q <= (now_q > swrm_pkg::TimeW'(cost_q)) ?
                     now_q - swrm_pkg::TimeW'(cost_q) : '0;
          state_q <= ST_LIMIT;
        end
        ST_LIMIT: begin
          lim_ok_q  <= (start_q >= swrm_pkg::TimeW'(window_q));
          limit_q   <= start_q - swrm_pkg::TimeW'(window_q);
          evicted_q <= 1'b0;
          state_q   <= ST_EVICT;
        end
        ST_EVICT: begin
          if (!evict_hit) begin
            state_q <= ST_OVF;
          end
        end
        ST_OVF: begin
          // A full ring drops its oldest entry to make room.
          if (pop) begin
            ovf_q <= 1'b1;
          end
          state_q <= ST_APPEND;
        end
        ST_APPEND: begin
          count_q    <= count_q + 1'b1;
          sum_ev_q   <= sum_ev_q + swrm_pkg::SumEvW'(ev_q);
          sum_cost_q <= sum_cost_q + swrm_pkg::SumCostW'(cost_q);
          state_q    <= ST_CACHE;
        end
        ST_CACHE: begin
          if (enough) begin
            cache_idle_q <= 1'b0;
            cache_ev_q   <= sum_ev_q;
            cache_cost_q <= sum_cost_q;
            if (evicted_q) begin
              cache_span_q <= window_q;
            end else if (start_q > head_entry.stamp) begin
              cache_span_q <= swrm_pkg::SpanW'(start_q - head_entry.stamp);
            end else begin
              cache_span_q <= '0;
            end
            upd_q <= 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {1'b0,
                          ovf_q,
                          cache_span_q,
                          cache_cost_q[swrm_pkg::OutCostW-1:0],
                          cache_ev_q[swrm_pkg::OutEvW-1:0],
                          cache_idle_q,
                          upd_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- hw/rtl/swrm_checker.sv -----
module swrm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [swrm_pkg::OutDataW-1:0] m_axis_tdata
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // One request is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A refreshed cache is never marked idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
    else $error("updated result marked idle");

  // An idle cache holds zero totals and span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> (m_axis_tdata[93:2] == '0))
    else $error("idle cache with nonzero contents");

endmodule

bind sliding_time_window_rate_meter swrm_checker u_swrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int TimeW        = swrm_pkg::TimeW;
  localparam int EvW          = swrm_pkg::EvW;
  localparam int CostW        = swrm_pkg::CostW;
  localparam int WindowW      = swrm_pkg::WindowW;
  localparam int MinW         = swrm_pkg::MinW;
  localparam int SumEvW       = swrm_pkg::SumEvW;
  localparam int SumCostW     = swrm_pkg::SumCostW;
  localparam int OutEvW       = swrm_pkg::OutEvW;
  localparam int OutCostW     = swrm_pkg::OutCostW;
  localparam int SpanW        = swrm_pkg::SpanW;
  localparam int InDataW      = swrm_pkg::InDataW;
  localparam int OutDataW     = swrm_pkg::OutDataW;
  localparam int CfgIdxW      = swrm_pkg::CfgIdxW;
  localparam int CfgDataW     = swrm_pkg::CfgDataW;
  localparam int HistoryDepth = swrm_pkg::HistoryDepth;
  localparam int IdxW         = swrm_pkg::IdxW;
  localparam int CntW         = swrm_pkg::CntW;

  // The run ends here with a failure if the traffic has not drained by then.
  localparam int CycleLimit = 1_000_000;

  // One sample or clear request, as the sender queues it.
  typedef struct {
    swrm_pkg::cmd_e    cmd;
    logic [TimeW-1:0]  now;
    logic [EvW-1:0]    events;
    logic [CostW-1:0]  cost;
  } meter_req_t;

  // The cached rate and flags that one request should report.
  typedef struct packed {
    logic                updated;
    logic                idle;
    logic [OutEvW-1:0]   event_total;
    logic [OutCostW-1:0] cost_total;
    logic [SpanW-1:0]    span;
    logic                overflowed;
  } rate_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                s_user = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  sliding_time_window_rate_meter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    // Bits from 0 up: now_us, events, cost_us.
    .s_axis_tdata  (s_data),
    // Bit 0: command.
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    // Bits from 0 up: updated, idle, event_total, cost_total, span_us, overflowed, pad.
    .m_axis_tdata  (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the meter. It holds its own copy of the sample history, the
  // running sums and the rate cache, and it is advanced once per accepted
  // request, so the store of expected reports stays in acceptance order.
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0]    hist_time [HistoryDepth];
  logic [EvW-1:0]      hist_events [HistoryDepth];
  logic [CostW-1:0]    hist_cost [HistoryDepth];
  logic [IdxW-1:0]     hist_head = '0;
  logic [CntW-1:0]     hist_count = '0;
  logic [SumEvW-1:0]   run_events = '0;
  logic [SumCostW-1:0] run_cost = '0;
  logic                cached_idle = 1'b1;
  logic [SumEvW-1:0]   cached_events = '0;
  logic [SumCostW-1:0] cached_cost = '0;
  logic [SpanW-1:0]    cached_span = '0;

  // Register copies; they start at the reset values of the block.
  logic [WindowW-1:0]  window_setting = swrm_pkg::WindowReset;
  logic [MinW-1:0]     min_setting = swrm_pkg::MinReset;

  meter_req_t   pending_reqs[$];
  rate_report_t expected_reports[$];
  int           error_count = 0;
  int           report_index = 0;
  logic [TimeW-1:0] time_base = '0;

  // Removes the oldest held sample and takes it out of the running sums.
  function automatic void retire_oldest();
    run_events  = run_events - SumEvW'(hist_events[hist_head]);
    run_cost    = run_cost - SumCostW'(hist_cost[hist_head]);
    hist_head   = IdxW'(hist_head + 1'b1);
    hist_count  = hist_count - 1'b1;
  endfunction

  function automatic rate_report_t rate_after(meter_req_t req);
    logic [TimeW-1:0] start;
    logic [IdxW-1:0]  tail;
    logic             evicted;
    rate_report_t     rep;
    evicted = 1'b0;
    rep = '0;
    if (req.cmd == swrm_pkg::CMD_CLEAR) begin
      hist_head     = '0;
      hist_count    = '0;
      run_events    = '0;
      run_cost      = '0;
      cached_idle   = 1'b1;
      cached_events = '0;
      cached_cost   = '0;
      cached_span   = '0;
    end else begin
      // The sample began cost_us before now, but never before time zero.
      start = (req.now > TimeW'(req.cost)) ? req.now - TimeW'(req.cost) : '0;
      // Age out everything strictly older than the window ahead of start.
      if (start >= TimeW'(window_setting)) begin
        while (hist_count > 0 && hist_time[hist_head] < start - TimeW'(window_setting)) begin
          retire_oldest();
          evicted = 1'b1;
        end
      end
      // A full history makes room by dropping its oldest sample.
      if (hist_count >= HistoryDepth) begin
        retire_oldest();
        evicted = 1'b1;
        rep.overflowed = 1'b1;
      end
      tail = IdxW'(hist_head + hist_count);
      hist_time[tail]   = start;
      hist_events[tail] = req.events;
      hist_cost[tail]   = req.cost;
      hist_count        = hist_count + 1'b1;
      run_events        = run_events + SumEvW'(req.events);
      run_cost          = run_cost + SumCostW'(req.cost);
      if (hist_count >= min_setting) begin
        cached_idle   = 1'b0;
        cached_events = run_events;
        cached_cost   = run_cost;
        if (evicted) begin
          cached_span = window_setting;
        end else if (start > hist_time[hist_head]) begin
          cached_span = SpanW'(start - hist_time[hist_head]);
        end else begin
          cached_span = '0;
        end
        rep.updated = 1'b1;
      end
    end
    rep.idle        = cached_idle;
    rep.event_total = cached_events[OutEvW-1:0];
    rep.cost_total  = cached_cost[OutCostW-1:0];
    rep.span        = cached_span;
    return rep;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch: report %0d %s: got %0h, expected %0h", report_index, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender. It takes requests from the pending queue in bursts of random
  // length and leaves random gaps between bursts; a third of the bursts have
  // no gap after them, so long back-to-back stretches happen too. The shadow
  // is advanced at the very edge at which the block accepts a request.
  // ---------------------------------------------------------------------------
  meter_req_t active_req;
  int         burst_left = 1;
  int         gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        expected_reports.insert(expected_reports.size(), rate_after(active_req));
      end
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          active_req = pending_reqs.pop_front();
          s_valid <= 1'b1;
          s_data  <= {active_req.cost, active_req.events, active_req.now};
          s_user  <= active_req.cmd;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Its readiness cycles through four moods in turn:
  // always ready, a coin toss, long stalls now and then, and mostly ready.
  // Every accepted report is checked field by field against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  int unsigned rx_cycle = 0;
  int          rx_stall = 0;

  always @(posedge clk_i) begin
    rate_report_t got;
    rate_report_t want;
    rx_cycle++;
    case (rx_cycle[8:7])
      2'd0: begin
        m_ready <= 1'b1;
      end
      2'd1: begin
        m_ready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        if (rx_stall > 0) begin
          rx_stall--;
          m_ready <= 1'b0;
        end else begin
          m_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 40);
        end
      end
      default: begin
        m_ready <= ($urandom_range(0, 3) != 0);
      end
    endcase

    if (rst_ni && m_valid && m_ready) begin
      got.updated     = m_data[0];
      got.idle        = m_data[1];
      got.event_total = m_data[23:2];
      got.cost_total  = m_data[61:24];
      got.span        = m_data[93:62];
      got.overflowed  = m_data[94];
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report", m_data[63:0], '0);
      end else begin
        want = expected_reports.pop_front();
        if (got.updated != want.updated)
          report_mismatch("updated", 64'(got.updated), 64'(want.updated));
        if (got.idle != want.idle)
          report_mismatch("idle", 64'(got.idle), 64'(want.idle));
        if (got.event_total != want.event_total)
          report_mismatch("event_total", 64'(got.event_total), 64'(want.event_total));
        if (got.cost_total != want.cost_total)
          report_mismatch("cost_total", 64'(got.cost_total), 64'(want.cost_total));
        if (got.span != want.span)
          report_mismatch("span_us", 64'(got.span), 64'(want.span));
        if (got.overflowed != want.overflowed)
          report_mismatch("overflowed", 64'(got.overflowed), 64'(want.overflowed));
      end
      report_index++;
    end
  end

  // Watchdog: a hang or lost report ends the run here.
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  task automatic queue_req(swrm_pkg::cmd_e cmd, logic [TimeW-1:0] now,
                           logic [EvW-1:0] events, logic [CostW-1:0] cost);
    meter_req_t req;
    req.cmd    = cmd;
    req.now    = now;
    req.events = events;
    req.cost   = cost;
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  // Holds the stimulus back until every queued request has been accepted and
  // every expected report has come back, then lets the block settle.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_valid || expected_reports.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  // The block is idle whenever this runs, so the shadow copies of the
  // registers can change at once.
  task automatic write_registers(logic [WindowW-1:0] window, logic [MinW-1:0] min_cnt);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= swrm_pkg::CFG_WINDOW;
    cfg_data <= window;
    @(posedge clk_i);
    cfg_idx  <= swrm_pkg::CFG_MIN_ENTRIES;
    cfg_data <= CfgDataW'(min_cnt);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    window_setting = window;
    min_setting    = min_cnt;
  endtask

  // One phase of random traffic. Most requests are samples whose time moves
  // forward by steps scaled to the window, so the history fills, ages out
  // and refreshes the cache. In a deep phase the steps stay short and no
  // clears or time jumps occur, so the history runs full and overflows.
  // Other phases mix in clears, backward and far jumps of the time, and costs
  // larger than the time itself.
  task automatic run_phase(logic [WindowW-1:0] window, logic [MinW-1:0] min_cnt,
                           int shift, bit deep, int n_reqs);
    int unsigned      base;
    int unsigned      pick;
    logic [TimeW-1:0] step;
    logic [TimeW-1:0] now;
    logic [CostW-1:0] cost;
    logic [EvW-1:0]   events;
    wait_quiet();
    write_registers(window, min_cnt);
    base = window >> shift;
    for (int i = 0; i < n_reqs; i++) begin
      pick = $urandom_range(0, 15);
      if (deep && (pick == 0 || pick == 1 || pick == 14)) pick = 15;
      case ($urandom_range(0, 7))
        0:       cost = '0;
        1:       cost = $urandom;
        2:       cost = '1;
        default: cost = $urandom_range(0, 5000);
      endcase
      case ($urandom_range(0, 7))
        0:       events = '0;
        1:       events = '1;
        default: events = EvW'($urandom);
      endcase
      if (pick == 0) begin
        queue_req(swrm_pkg::CMD_CLEAR, {16'($urandom), 32'($urandom)}, events, cost);
      end else if (pick == 1) begin
        // Free-running time: may jump far ahead or back behind held samples.
        queue_req(swrm_pkg::CMD_SAMPLE, {16'($urandom), 32'($urandom)}, events, $urandom);
      end else begin
        if (pick == 2) step = '0;
        else if (pick <= 9) step = TimeW'($urandom_range(0, base + 1));
        else if (pick <= 13) step = TimeW'(base) * TimeW'($urandom_range(2, 8));
        else if (pick == 14) step = TimeW'(window) + TimeW'($urandom_range(1, 1000));
        else step = TimeW'($urandom_range(1, 50));
        now = time_base + step;
        time_base = (now < time_base) ? '1 : now;
        queue_req(swrm_pkg::CMD_SAMPLE, time_base, events, cost);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset register values.
    queue_req(swrm_pkg::CMD_CLEAR, '1, '1, '1);
    queue_req(swrm_pkg::CMD_SAMPLE, 48'd0, 16'd0, 32'd0);
    // Cost above now: the start time saturates at zero.
    queue_req(swrm_pkg::CMD_SAMPLE, 48'd100, 16'hFFFF, 32'd1000);
    queue_req(swrm_pkg::CMD_SAMPLE, 48'd1000, 16'd1, 32'hFFFF_FFFF);
    // Far enough ahead that every held sample ages out; too few are then held to refresh the cache.
    queue_req(swrm_pkg::CMD_SAMPLE, 48'd20_000_000, 16'd2, 32'd0);
    queue_req(swrm_pkg::CMD_SAMPLE, 48'd20_000_100, 16'd3, 32'd0);
    // Start lands before the oldest held sample: the span saturates at zero.
    queue_req(swrm_pkg::CMD_SAMPLE, 48'd20_000_200, 16'd4, 32'd1000);
    queue_req(swrm_pkg::CMD_SAMPLE, 48'hFFFF_FFFF_FFFF, 16'hAAAA, 32'h5555_5555);
    queue_req(swrm_pkg::CMD_SAMPLE, 48'h8000_0000_0000, 16'h5555, 32'hAAAA_AAAA);
    queue_req(swrm_pkg::CMD_SAMPLE, 48'h5555_5555_5555, 16'h0000, 32'h0000_0000);
    queue_req(swrm_pkg::CMD_SAMPLE, 48'hAAAA_AAAA_AAAA, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(swrm_pkg::CMD_CLEAR, '0, '0, '0);
    // Too few samples after a clear: the cache stays idle.
    queue_req(swrm_pkg::CMD_SAMPLE, 48'd5, 16'd7, 32'd3);
    queue_req(swrm_pkg::CMD_SAMPLE, 48'd9, 16'd1, 32'd2);

    // Random phases across the register range, extremes included.
    run_phase(32'hFFFF_FFFF, 7'd64, 10, 1'b1, 200);
    run_phase(32'd1, 7'd1, 4, 1'b0, 170);
    run_phase($urandom_range(1000, 1_000_000), 7'd0, 4, 1'b0, 170);
    run_phase(32'd15_000_000, 7'd127, 4, 1'b0, 120);
    run_phase($urandom, 7'd2, 4, 1'b0, 170);
    run_phase($urandom_range(1, 50_000_000), MinW'($urandom_range(1, 64)), 4, 1'b0, 170);
    run_phase(32'd100_000, 7'd5, 4, 1'b0, 170);
    run_phase(32'hFFFF_FFFF, 7'd1, 9, 1'b1, 230);

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/swrm_pkg.sv
hw/rtl/swrm_ring.sv
hw/rtl/sliding_time_window_rate_meter.sv
hw/rtl/swrm_checker.sv
tb/sv/testbench.sv
